>>> hw/rtl/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg
// Types and constants shared by the haptic drive sequencer modules.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int DUR_W    = 16;
  localparam int WDOG_W   = 16;
  localparam int BRAKE_W  = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam int unsigned BRAKE_LONG  = 10;
  localparam int unsigned BRAKE_SHORT = 5;
  localparam logic [BRAKE_W-1:0] BRAKE_AUTO_BIT  = 8'h40;
  localparam logic [BRAKE_W-1:0] BRAKE_TIME_BITS = 8'h30;
  localparam logic [BRAKE_W-1:0] BRAKE_RESET     = 8'h18;

  typedef enum logic [1:0] {
    PH_STOP    = 2'd0,
    PH_SETUP   = 2'd1,
    PH_WORKING = 2'd2,
    PH_BRAKING = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WATCHDOG = 1'b0,
    REG_BRK      = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             req_type;
    logic [DUR_W-1:0] duration_ms;
    logic             bus_write_fail;
  } in_item_t;

  typedef struct packed {
    logic [WDOG_W-1:0]  watchdog_limit_ms;
    logic [BRAKE_W-1:0] brake_setting;
  } cfg_t;

  typedef struct packed {
    logic             motor_enable;
    logic             reset_release;
    logic [1:0]       phase;
    logic [DUR_W-1:0] remaining_ms;
    logic             auto_stopped;
    logic             write_table;
  } res_t;

endpackage

>>> hw/rtl/hds_cfg_regs.sv
// ----------------------------------------------------------------------------
// hds_cfg_regs
// Watchdog limit and brake control registers behind the write port.
// ----------------------------------------------------------------------------
module hds_cfg_regs
  import hds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_WATCHDOG: cfg_nxt.watchdog_limit_ms = wr_data[WDOG_W-1:0];
        REG_BRK:      cfg_nxt.brake_setting     = wr_data[BRAKE_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.watchdog_limit_ms <= '0;
      cfg_r.brake_setting     <= BRAKE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/hds_in_stage.sv
// ----------------------------------------------------------------------------
// hds_in_stage
// Input register: holds one accepted beat until the step logic takes it.
// ----------------------------------------------------------------------------
module hds_in_stage
  import hds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r, item_nxt;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      item_nxt  = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> hw/rtl/hds_step.sv
// ----------------------------------------------------------------------------
// hds_step
// Phase sequencer state and the update it applies for a tick or a request.
// ----------------------------------------------------------------------------
module hds_step
  import hds_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  input  cfg_t     cfg,
  output res_t     res
);

  phase_t               mode_r, mode_nxt;
  logic [TIME_BITS-1:0] main_count_r, main_count_nxt;
  logic                 main_armed_r, main_armed_nxt;
  logic [TIME_BITS-1:0] watch_count_r, watch_count_nxt;
  logic                 watch_armed_r, watch_armed_nxt;
  logic [TIME_BITS-1:0] req_time_r, req_time_nxt;
  logic [TIME_BITS-1:0] stored_rem_r, stored_rem_nxt;
  logic                 autostop_r, autostop_nxt;
  logic                 stop_pend_r, stop_pend_nxt;
  logic                 enable_r, enable_nxt;
  logic                 reset_lvl_r, reset_lvl_nxt;

  logic [TIME_BITS-1:0] dur;
  logic [TIME_BITS-1:0] wdog_len;
  logic [TIME_BITS-1:0] brake_len;
  logic [TIME_BITS-1:0] rem;
  logic                 wrote;
  logic                 do_disp;

  assign dur      = TIME_BITS'(item.duration_ms);
  assign wdog_len = TIME_BITS'(cfg.watchdog_limit_ms);

  // brake length: 1 if auto and time bits are clear, else from req_time_nxt
  always_comb begin
    if (((cfg.brake_setting & BRAKE_AUTO_BIT) == '0) &&
        ((cfg.brake_setting & BRAKE_TIME_BITS) == '0)) begin
      brake_len = TIME_BITS'(1);
    end else if (req_time_nxt >= TIME_BITS'(BRAKE_LONG)) begin
      brake_len = TIME_BITS'(BRAKE_LONG);
    end else begin
      brake_len = TIME_BITS'(BRAKE_SHORT);
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    main_count_nxt  = main_count_r;
    main_armed_nxt  = main_armed_r;
    watch_count_nxt = watch_count_r;
    watch_armed_nxt = watch_armed_r;
    req_time_nxt    = req_time_r;
    stored_rem_nxt  = stored_rem_r;
    autostop_nxt    = autostop_r;
    stop_pend_nxt   = stop_pend_r;
    enable_nxt      = enable_r;
    reset_lvl_nxt   = reset_lvl_r;
    wrote           = 1'b0;
    do_disp         = 1'b0;

    if (item.req_type) begin
      req_time_nxt = dur;
      if (dur == '0) begin
        // stop now: drop the watchdog, disable the motor and brake
        stop_pend_nxt   = 1'b1;
        watch_armed_nxt = 1'b0;
        enable_nxt      = 1'b0;
        main_count_nxt  = brake_len;
        main_armed_nxt  = 1'b1;
        mode_nxt        = PH_BRAKING;
        stored_rem_nxt  = '0;
      end else begin
        stop_pend_nxt  = 1'b0;
        stored_rem_nxt = dur;
        autostop_nxt   = 1'b0;
        do_disp        = 1'b1;
      end
    end else begin
      if (main_armed_r && main_count_r != '0) begin
        main_count_nxt = main_count_r - TIME_BITS'(1);
      end
      if (watch_armed_r && watch_count_r != '0) begin
        watch_count_nxt = watch_count_r - TIME_BITS'(1);
      end
      if (main_armed_r && main_count_nxt == '0) begin
        main_armed_nxt = 1'b0;
        do_disp        = 1'b1;
      end
    end

    if (do_disp) begin
      case (mode_r)
        PH_STOP: begin
          if (!autostop_nxt) begin
            if (!stop_pend_nxt) begin
              reset_lvl_nxt = 1'b1;
            end
            main_count_nxt = TIME_BITS'(1);
            main_armed_nxt = 1'b1;
            mode_nxt       = PH_SETUP;
          end
        end
        PH_SETUP: begin
          wrote = 1'b1;
          if (item.bus_write_fail) begin
            mode_nxt = PH_STOP;
          end else begin
            enable_nxt = !stop_pend_nxt;
            if (req_time_nxt != '0) begin
              main_count_nxt = req_time_nxt;
              main_armed_nxt = 1'b1;
            end
            if (wdog_len != '0) begin
              watch_count_nxt = wdog_len;
              watch_armed_nxt = 1'b1;
            end
            mode_nxt = PH_WORKING;
          end
        end
        PH_WORKING: begin
          watch_armed_nxt = 1'b0;
          enable_nxt      = 1'b0;
          main_count_nxt  = brake_len;
          main_armed_nxt  = 1'b1;
          mode_nxt        = PH_BRAKING;
          stored_rem_nxt  = '0;
        end
        PH_BRAKING: begin
          reset_lvl_nxt = 1'b0;
          mode_nxt      = PH_STOP;
        end
        default: mode_nxt = mode_r;
      endcase
    end

    // watchdog is looked at after the main timer on the same tick
    if (!item.req_type && watch_armed_nxt && watch_count_nxt == '0) begin
      watch_armed_nxt = 1'b0;
      main_armed_nxt  = 1'b0;
      enable_nxt      = 1'b0;
      main_count_nxt  = brake_len;
      main_armed_nxt  = 1'b1;
      mode_nxt        = PH_BRAKING;
      stored_rem_nxt  = '0;
      autostop_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= PH_STOP;
      main_count_r  <= '0;
      main_armed_r  <= 1'b0;
      watch_count_r <= '0;
      watch_armed_r <= 1'b0;
      req_time_r    <= '0;
      stored_rem_r  <= '0;
      autostop_r    <= 1'b0;
      stop_pend_r   <= 1'b0;
      enable_r      <= 1'b0;
      reset_lvl_r   <= 1'b0;
    end else if (fire) begin
      mode_r        <= mode_nxt;
      main_count_r  <= main_count_nxt;
      main_armed_r  <= main_armed_nxt;
      watch_count_r <= watch_count_nxt;
      watch_armed_r <= watch_armed_nxt;
      req_time_r    <= req_time_nxt;
      stored_rem_r  <= stored_rem_nxt;
      autostop_r    <= autostop_nxt;
      stop_pend_r   <= stop_pend_nxt;
      enable_r      <= enable_nxt;
      reset_lvl_r   <= reset_lvl_nxt;
    end
  end

  always_comb begin
    if (mode_nxt == PH_WORKING) begin
      rem = main_armed_nxt ? main_count_nxt : '0;
    end else begin
      rem = stored_rem_nxt;
    end
  end

  always_comb begin
    res.motor_enable  = enable_nxt;
    res.reset_release = reset_lvl_nxt;
    res.phase         = mode_nxt;
    res.remaining_ms  = DUR_W'(rem);
    res.auto_stopped  = autostop_nxt;
    res.write_table   = wrote;
  end

endmodule

>>> hw/rtl/hds_out_stage.sv
// ----------------------------------------------------------------------------
// hds_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module hds_out_stage
  import hds_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r, valid_nxt;
  res_t res_r, res_nxt;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> hw/rtl/haptic_drive_sequencer_core.sv
// ----------------------------------------------------------------------------
// haptic_drive_sequencer_core
// Vibration motor driver sequencer: stop, setup, working and braking phases
// stepped by 1 ms ticks and vibrate requests.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, req_type, dur, fail  | input
//  out     | out_valid/out_ready, pins, phase, rem   | output
//  cfg     | cfg_valid/cfg_ready, cfg_index/cfg_data | input
//
// one beat per cycle unless the output stalls; an accepted beat sits in the
// input register until the result register can take it, and is stepped at
// the edge that loads its result and sets out_valid.
// rst_n is synchronous; reset leaves the phase in stop with reset held.
// a stalled output holds the input register, which back-pressures in_ready.
// cfg writes are always taken.
// ----------------------------------------------------------------------------
module haptic_drive_sequencer_core
  import hds_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [DUR_W-1:0]     in_duration_ms,
  input  logic                 in_bus_write_fail,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_motor_enable,
  output logic                 out_reset_release,
  output logic [1:0]           out_phase,
  output logic [DUR_W-1:0]     out_remaining_ms,
  output logic                 out_auto_stopped,
  output logic                 out_write_table,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     can_load;
  logic     fire;
  cfg_t     cfg;
  res_t     res;
  res_t     out_res;

  assign cfg_ready = 1'b1;

  assign in_item.req_type       = in_req_type;
  assign in_item.duration_ms    = in_duration_ms;
  assign in_item.bus_write_fail = in_bus_write_fail;

  assign fire = item_valid && can_load;

  hds_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  hds_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  hds_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  hds_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_motor_enable  = out_res.motor_enable;
  assign out_reset_release = out_res.reset_release;
  assign out_phase         = out_res.phase;
  assign out_remaining_ms  = out_res.remaining_ms;
  assign out_auto_stopped  = out_res.auto_stopped;
  assign out_write_table   = out_res.write_table;

endmodule
